// ===== hdl/pdf_pkg.sv =====
package pdf_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 12;
    localparam int POLY_FRAC = 28;

    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_F      = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint HALF_PI_F =
        (HALF_PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint TWO_PI_F  = 2 * PI_F;
    localparam longint ONE_F     = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF_F    = 64'sd1 <<< (FRAC_BITS - 1);
    localparam longint LIM_XY    = ((64'sd15 <<< FRAC_BITS) + 50) / 100;
    localparam longint LIM_Z_LO  = ((64'sd465 <<< FRAC_BITS) + 500) / 1000;
    localparam longint LIM_Z_HI  = HALF_F;
    localparam longint LIM_TURN  = ((64'sd8 <<< FRAC_BITS) + 5) / 10;

    // Pipeline shape: input stage, three sine cells of three stages, then three more
    localparam int N_CELLS  = 3;
    localparam int CELL_LAT = 3;
    localparam int SIDE_LEN = N_CELLS * CELL_LAT;
    localparam int N_STAGES = SIDE_LEN + 4;

    // Taylor divisors (innermost first) and floor(2^32/k) reciprocals
    localparam logic [5:0]  DIV_TAB   [N_CELLS] = '{6'd42, 6'd20, 6'd6};
    localparam logic [29:0] RECIP_TAB [N_CELLS] = '{
        30'((64'd1 << 32) / 42), 30'((64'd1 << 32) / 20), 30'((64'd1 << 32) / 6)};

    // Reset values of the gain registers
    localparam logic signed [14:0] RST_TARGET_HEADING = 15'sd0;
    localparam logic [15:0] RST_KP_PLANAR   = 16'd2048;
    localparam logic [15:0] RST_KD_PLANAR   = 16'd3277;
    localparam logic [15:0] RST_KP_VERTICAL = 16'd4096;
    localparam logic [15:0] RST_KD_VERTICAL = 16'd2048;
    localparam logic [15:0] RST_KP_HEADING  = 16'd4096;
    localparam logic [15:0] RST_KD_HEADING  = 16'd2048;
    localparam logic [15:0] RST_HOVER_BIAS  = 16'd6001;

    typedef enum logic [2:0] {
        REG_TARGET_HEADING = 3'd0,
        REG_KP_PLANAR      = 3'd1,
        REG_KD_PLANAR      = 3'd2,
        REG_KP_VERTICAL    = 3'd3,
        REG_KD_VERTICAL    = 3'd4,
        REG_KP_HEADING     = 3'd5,
        REG_KD_HEADING     = 3'd6,
        REG_HOVER_BIAS     = 3'd7
    } t_reg_idx;

    // Folded angle: sign and magnitude in [0, pi/2]
    typedef struct packed {
        logic        neg;
        logic [12:0] x;
    } t_fold;

    // Data passed from one sine cell to the next
    typedef struct packed {
        logic [29:0] x2;
        logic [28:0] t;
    } t_poly;

    typedef struct packed {
        logic signed [41:0] pkx;
        logic signed [41:0] pdx;
        logic signed [41:0] pky;
        logic signed [41:0] pdy;
        logic signed [41:0] pkz;
        logic signed [41:0] pdz;
        logic signed [41:0] pkh;
        logic signed [41:0] pdh;
        t_fold [1:0]        fld;
        logic [1:0][29:0]   x2;
    } t_s1;

    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] uyaw;
        t_fold [1:0]        fld;
    } t_side;

    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic signed [31:0] uyaw;
        logic signed [14:0] sn;
        logic signed [14:0] cs;
    } t_s11;

    typedef struct packed {
        logic signed [46:0] p_xc;
        logic signed [46:0] p_ys;
        logic signed [46:0] p_yc;
        logic signed [46:0] p_xs;
        logic signed [31:0] uz;
        logic signed [31:0] uyaw;
    } t_s12;

    // Shift right by FRAC_BITS, round half away from zero
    function automatic logic signed [47:0] rnd48(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] q;
        mag = v[47] ? 48'(-v) : 48'(v);
        q   = (mag + 48'(HALF_F)) >> FRAC_BITS;
        return v[47] ? -signed'(q) : signed'(q);
    endfunction

    function automatic logic signed [47:0] clamp48(input logic signed [47:0] v,
                                                   input logic signed [47:0] lo,
                                                   input logic signed [47:0] hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Reduce angle modulo 2pi into [-pi, pi), then fold into [0, pi/2]
    function automatic t_fold fold_angle(input logic signed [17:0] a);
        logic signed [18:0] r;
        logic signed [18:0] m;
        t_fold f;
        r = 19'(a) + 19'(PI_F);
        if (r < 0) begin
            r = r + 19'(TWO_PI_F);
        end else if (r >= 19'(TWO_PI_F)) begin
            r = r - 19'(TWO_PI_F);
        end
        r = r - 19'(PI_F);
        f.neg = r[18];
        m = r[18] ? -r : r;
        if (m > 19'(HALF_PI_F)) begin
            m = 19'(PI_F) - m;
        end
        f.x = m[12:0];
        return f;
    endfunction

endpackage

// ===== hdl/pd_follow_accel_controller.sv =====
// Channel   | Direction | Handshake                    | Payload
// input     | in        | i_in_valid / o_in_stall      | i_leader_p*, i_own_p*, i_own_v*, heading
// result    | out       | o_out_valid / i_out_stall    | o_cmd_ax, o_cmd_ay, o_cmd_az, o_cmd_turn
// config    | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One request is taken every cycle while the output is not stalled.
// The depth is set by the sine/cosine chain: three Horner cells of three stages each.
// A stalled result freezes the whole pipeline, and o_in_stall follows it.
// Synchronous active-low reset clears the stage valid bits and restores the gains.
module pd_follow_accel_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic signed [23:0] i_leader_px,
    input  logic signed [23:0] i_leader_py,
    input  logic signed [23:0] i_leader_pz,
    input  logic signed [23:0] i_own_px,
    input  logic signed [23:0] i_own_py,
    input  logic signed [23:0] i_own_pz,
    input  logic signed [14:0] i_own_heading,
    input  logic signed [23:0] i_own_vx,
    input  logic signed [23:0] i_own_vy,
    input  logic signed [23:0] i_own_vz,
    input  logic signed [23:0] i_own_heading_rate,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic signed [10:0] o_cmd_ax,
    output logic signed [10:0] o_cmd_ay,
    output logic        [11:0] o_cmd_az,
    output logic signed [12:0] o_cmd_turn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pdf_pkg::*;

    // Gain registers
    logic signed [14:0] r_target_heading;
    logic [15:0] r_kp_planar, r_kd_planar, r_kp_vertical, r_kd_vertical;
    logic [15:0] r_kp_heading, r_kd_heading, r_hover_bias;
    t_reg_idx    w_idx;

    logic        w_en;
    logic        w_accept;
    logic [N_STAGES-1:0] r_vld;

    t_s1   n_s1, r_s1;
    t_side n_side;
    t_side r_side [SIDE_LEN];
    t_s11  n_s11, r_s11;
    t_s12  n_s12, r_s12;

    t_poly w_chain [2][N_CELLS+1];
    logic signed [14:0] w_trig [2];

    logic signed [10:0] n_ax, n_ay;
    logic        [11:0] n_az;
    logic signed [12:0] n_turn;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_heading <= RST_TARGET_HEADING;
            r_kp_planar      <= RST_KP_PLANAR;
            r_kd_planar      <= RST_KD_PLANAR;
            r_kp_vertical    <= RST_KP_VERTICAL;
            r_kd_vertical    <= RST_KD_VERTICAL;
            r_kp_heading     <= RST_KP_HEADING;
            r_kd_heading     <= RST_KD_HEADING;
            r_hover_bias     <= RST_HOVER_BIAS;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_TARGET_HEADING: r_target_heading <= signed'(pwdata[14:0]);
                REG_KP_PLANAR:      r_kp_planar      <= pwdata[15:0];
                REG_KD_PLANAR:      r_kd_planar      <= pwdata[15:0];
                REG_KP_VERTICAL:    r_kp_vertical    <= pwdata[15:0];
                REG_KD_VERTICAL:    r_kd_vertical    <= pwdata[15:0];
                REG_KP_HEADING:     r_kp_heading     <= pwdata[15:0];
                REG_KD_HEADING:     r_kd_heading     <= pwdata[15:0];
                REG_HOVER_BIAS:     r_hover_bias     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (w_idx)
            REG_TARGET_HEADING: prdata = 32'(r_target_heading);
            REG_KP_PLANAR:      prdata = 32'(r_kp_planar);
            REG_KD_PLANAR:      prdata = 32'(r_kd_planar);
            REG_KP_VERTICAL:    prdata = 32'(r_kp_vertical);
            REG_KD_VERTICAL:    prdata = 32'(r_kd_vertical);
            REG_KP_HEADING:     prdata = 32'(r_kp_heading);
            REG_KD_HEADING:     prdata = 32'(r_kd_heading);
            REG_HOVER_BIAS:     prdata = 32'(r_hover_bias);
            default:            prdata = 32'd0;
        endcase
    end

    // Pipeline advance: everything holds while a result waits
    assign w_en       = !(r_vld[N_STAGES-1] && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_accept   = i_in_valid && w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[N_STAGES-2:0], w_accept};
        end
    end

    // Stage 1: gain products and angle folding
    always_comb begin
        logic signed [24:0] e_x, e_y, e_z;
        logic signed [15:0] e_h;
        logic [25:0] sq0, sq1;
        e_x = 25'(i_leader_px) - 25'(i_own_px);
        e_y = 25'(i_leader_py) - 25'(i_own_py);
        e_z = 25'(i_leader_pz) - 25'(i_own_pz);
        e_h = 16'(r_target_heading) - 16'(i_own_heading);
        n_s1.pkx = 42'(signed'({1'b0, r_kp_planar}))   * 42'(e_x);
        n_s1.pdx = 42'(signed'({1'b0, r_kd_planar}))   * 42'(i_own_vx);
        n_s1.pky = 42'(signed'({1'b0, r_kp_planar}))   * 42'(e_y);
        n_s1.pdy = 42'(signed'({1'b0, r_kd_planar}))   * 42'(i_own_vy);
        n_s1.pkz = 42'(signed'({1'b0, r_kp_vertical})) * 42'(e_z);
        n_s1.pdz = 42'(signed'({1'b0, r_kd_vertical})) * 42'(i_own_vz);
        n_s1.pkh = 42'(signed'({1'b0, r_kp_heading}))  * 42'(e_h);
        n_s1.pdh = 42'(signed'({1'b0, r_kd_heading}))  * 42'(i_own_heading_rate);
        // lane 0 sine, lane 1 cosine (sine of angle + pi/2)
        n_s1.fld[0] = fold_angle(18'(i_own_heading));
        n_s1.fld[1] = fold_angle(18'(i_own_heading) + 18'(HALF_PI_F));
        sq0 = 26'(n_s1.fld[0].x) * 26'(n_s1.fld[0].x);
        sq1 = 26'(n_s1.fld[1].x) * 26'(n_s1.fld[1].x);
        n_s1.x2[0] = {sq0, 4'b0000};
        n_s1.x2[1] = {sq1, 4'b0000};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    // Stage 2 side data: PD sums ride alongside the sine cells
    always_comb begin
        n_side.ux   = 32'(rnd48(48'(r_s1.pkx)) - rnd48(48'(r_s1.pdx)) - 48'(ONE_F));
        n_side.uy   = 32'(rnd48(48'(r_s1.pky)) - rnd48(48'(r_s1.pdy)));
        n_side.uz   = 32'(rnd48(48'(r_s1.pkz)) - rnd48(48'(r_s1.pdz))
                          + 48'(r_hover_bias));
        n_side.uyaw = 32'(rnd48(48'(r_s1.pkh)) - rnd48(48'(r_s1.pdh)));
        n_side.fld  = r_s1.fld;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int i = 1; i < SIDE_LEN; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Horner chains, one row of cells per lane
    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        assign w_chain[ln][0].x2 = r_s1.x2[ln];
        assign w_chain[ln][0].t  = 29'(64'd1 << POLY_FRAC);
        for (genvar c = 0; c < N_CELLS; c++) begin : g_cell
            pdf_sin_cell u_cell (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_poly  (w_chain[ln][c]),
                .i_div   (DIV_TAB[c]),
                .i_recip (RECIP_TAB[c]),
                .o_poly  (w_chain[ln][c+1])
            );
        end

        // s = x * t, back to Q.FRAC_BITS with rounding, sign restored
        always_comb begin
            logic [41:0] s;
            logic [13:0] q;
            s = (42'(r_side[SIDE_LEN-1].fld[ln].x) * 42'(w_chain[ln][N_CELLS].t))
                >> (POLY_FRAC - 16);
            q = 14'((s + 42'(64'd1 << (27 - FRAC_BITS))) >> (POLY_FRAC - FRAC_BITS));
            w_trig[ln] = r_side[SIDE_LEN-1].fld[ln].neg ? -signed'(15'(q))
                                                        : signed'(15'(q));
        end
    end

    // Stage 11: sine and cosine
    always_comb begin
        n_s11.ux   = r_side[SIDE_LEN-1].ux;
        n_s11.uy   = r_side[SIDE_LEN-1].uy;
        n_s11.uz   = r_side[SIDE_LEN-1].uz;
        n_s11.uyaw = r_side[SIDE_LEN-1].uyaw;
        n_s11.sn   = w_trig[0];
        n_s11.cs   = w_trig[1];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s11 <= n_s11;
        end
    end

    // Stage 12: rotation products
    always_comb begin
        n_s12.p_xc = 47'(r_s11.ux) * 47'(r_s11.cs);
        n_s12.p_ys = 47'(r_s11.uy) * 47'(r_s11.sn);
        n_s12.p_yc = 47'(r_s11.uy) * 47'(r_s11.cs);
        n_s12.p_xs = 47'(r_s11.ux) * 47'(r_s11.sn);
        n_s12.uz   = r_s11.uz;
        n_s12.uyaw = r_s11.uyaw;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s12 <= n_s12;
        end
    end

    // Stage 13: round, clamp, yaw offset
    always_comb begin
        logic signed [47:0] ax, ay, yw;
        ax = clamp48(rnd48(48'(r_s12.p_xc) + 48'(r_s12.p_ys)),
                     -48'(LIM_XY), 48'(LIM_XY));
        ay = clamp48(rnd48(48'(r_s12.p_yc) - 48'(r_s12.p_xs)),
                     -48'(LIM_XY), 48'(LIM_XY));
        yw = 48'(r_s12.uyaw);
        if (yw > 0) begin
            yw = yw + 48'(HALF_F);
        end else if (yw < 0) begin
            yw = yw - 48'(HALF_F);
        end
        yw     = clamp48(yw, -48'(LIM_TURN), 48'(LIM_TURN));
        n_ax   = 11'(-ax);
        n_ay   = 11'(ay);
        n_az   = 12'(clamp48(48'(r_s12.uz), 48'(LIM_Z_LO), 48'(LIM_Z_HI)));
        n_turn = 13'(yw);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_cmd_ax   <= n_ax;
            o_cmd_ay   <= n_ay;
            o_cmd_az   <= n_az;
            o_cmd_turn <= n_turn;
        end
    end

    assign o_out_valid = r_vld[N_STAGES-1];

    // Checks
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_s1.fld[0].x <= 13'(HALF_PI_F)) && (r_s1.fld[1].x <= 13'(HALF_PI_F)))
        else $error("folded angle above pi/2");

    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cmd_az >= 12'(LIM_Z_LO)) && (o_cmd_az <= 12'(LIM_Z_HI)))
        else $error("vertical command out of range");

    a_turn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_cmd_turn >= -13'(LIM_TURN)) && (o_cmd_turn <= 13'(LIM_TURN)))
        else $error("turn command out of range");

endmodule

// ===== hdl/pdf_sin_cell.sv =====
module pdf_sin_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  pdf_pkg::t_poly  i_poly,
    input  logic [5:0]      i_div,
    input  logic [29:0]     i_recip,
    output pdf_pkg::t_poly  o_poly
);
    import pdf_pkg::*;

    logic [58:0] w_prod_a;
    logic [59:0] w_prod_b;
    logic [29:0] w_qk;
    logic [29:0] w_rem;
    logic [27:0] w_q;

    logic [29:0] r_x2_a;
    logic [29:0] r_p_a;
    logic [29:0] r_x2_b;
    logic [29:0] r_p_b;
    logic [27:0] r_q_b;
    t_poly       r_poly;

    // One Horner step: t_out = 1 - ((x2 * t_in) >> 28) / k
    assign w_prod_a = 59'(i_poly.x2) * 59'(i_poly.t);
    assign w_prod_b = 60'(r_p_a) * 60'(i_recip);
    // quotient estimate is low by at most one
    assign w_qk  = 30'(r_q_b) * 30'(i_div);
    assign w_rem = r_p_b - w_qk;
    assign w_q   = (w_rem >= 30'(i_div)) ? r_q_b + 28'd1 : r_q_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x2_a      <= i_poly.x2;
            r_p_a       <= 30'(w_prod_a >> POLY_FRAC);
            r_x2_b      <= r_x2_a;
            r_p_b       <= r_p_a;
            r_q_b       <= 28'(w_prod_b >> 32);
            r_poly.x2   <= r_x2_b;
            r_poly.t    <= 29'(64'd1 << POLY_FRAC) - 29'(w_q);
        end
    end

    assign o_poly = r_poly;

endmodule
